// ----- rtl/core/uniform_grid_linear_resampler_top_macros.svh -----
// assertion macros for the uniform grid resampler checker
`ifndef UNIFORM_GRID_LINEAR_RESAMPLER_TOP_MACROS_SVH
`define UNIFORM_GRID_LINEAR_RESAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define UGR_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("resampler check failed");

// next-cycle implication
`define UGR_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("resampler check failed");

`endif

// ----- rtl/core/ugr_pkg.sv -----
// shared types and constants of the uniform grid resampler
package ugr_pkg;

  localparam int TIME_W     = 36;
  localparam int VAL_W      = 32;
  localparam int STEP_W     = 24;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 136;
  localparam int OUT_PAD_W  = OUT_DATA_W - (TIME_W + 3 * VAL_W);
  localparam int DY_W       = VAL_W + 1;
  localparam int MUL_SPLIT  = 18;
  localparam int MUL_W      = VAL_W + MUL_SPLIT;
  localparam int PROD_W     = VAL_W + TIME_W;
  localparam int QUO_W      = 32;
  localparam int DIV_CNT_W  = $clog2(QUO_W);

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(QUO_W - 1);

  localparam logic [STATUS_W-1:0] STATUS_VALID = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NEED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_STEP  = 2'd2;

  localparam logic [VAL_W-1:0]  VAL_MAX    = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0]  VAL_MIN    = 32'h8000_0000;
  localparam logic [TIME_W-1:0] TIME_MAX   = '1;
  localparam logic [STEP_W-1:0] STEP_RESET = 24'd16;

  typedef struct packed {
    logic push;
    logic tick;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic load_out;
  } ugr_cmd_t;

  typedef struct packed {
    logic tick_interp;
    logic out_free;
  } ugr_stat_t;

endpackage

// ----- rtl/core/ugr_ctrl.sv -----
// control state machine of the uniform grid resampler
module ugr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_kind,
  output logic                s_tready,
  output ugr_pkg::ugr_cmd_t   cmd,
  input  ugr_pkg::ugr_stat_t  stat
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL_LO = 3'd1;
  localparam logic [2:0] ST_MUL_HI = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]                      state, state_next;
  logic [ugr_pkg::DIV_CNT_W-1:0]   cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    s_tready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_kind == ugr_pkg::KIND_TICK) begin
            cmd.tick   = 1'b1;
            state_next = stat.tick_interp ? ST_MUL_LO : ST_FIN;
          end else begin
            cmd.push = 1'b1;
          end
        end
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == ugr_pkg::DIV_LAST) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/ugr_dp.sv -----
// datapath of the uniform grid resampler: state, multiplier, divider, output register
module ugr_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ugr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ugr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [ugr_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  input  ugr_pkg::ugr_cmd_t                 cmd,
  output ugr_pkg::ugr_stat_t                stat,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [ugr_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [ugr_pkg::STATUS_W-1:0]      m_tuser
);

  localparam int TW = ugr_pkg::TIME_W;
  localparam int VW = ugr_pkg::VAL_W;

  // configuration
  logic [TW-1:0]               end_time;
  logic [ugr_pkg::STEP_W-1:0]  grid_step;

  // sample state
  logic [TW-1:0]  older_time, newer_time, next_grid_time;
  logic [VW-1:0]  older_value, newer_value, running_min, running_max;
  logic [1:0]     samples_held;
  logic           final_seen;

  // work registers
  logic [TW-1:0]                 w_time, dx, dt, rem;
  logic [VW-1:0]                 w_value, ady, dvd;
  logic [ugr_pkg::QUO_W-1:0]     quo;
  logic [ugr_pkg::STATUS_W-1:0]  w_status;
  logic                          neg;
  logic [ugr_pkg::MUL_W-1:0]     p_lo, p_hi;

  // output register
  logic                          out_valid;
  logic [TW-1:0]                 o_time;
  logic [VW-1:0]                 o_value, o_min, o_max;
  logic [ugr_pkg::STATUS_W-1:0]  o_status;

  logic [TW-1:0]                 st;
  logic [VW-1:0]                 sv;
  logic [ugr_pkg::STATUS_W-1:0]  dec_status;
  logic [VW-1:0]                 dec_value;
  logic                          dec_interp;
  logic [ugr_pkg::DY_W-1:0]      dy, dy_abs;
  logic [ugr_pkg::PROD_W-1:0]    prod;
  logic [TW:0]                   rem2, rem_sub;
  logic                          q_bit;
  logic [TW:0]                   nx;
  logic [VW-1:0]                 fin_value;

  assign st = s_tdata[TW-1:0];
  assign sv = s_tdata[TW+VW-1:TW];

  // tick decision on the current grid time
  always_comb begin
    dec_status = ugr_pkg::STATUS_VALID;
    dec_value  = '0;
    dec_interp = 1'b0;
    priority if (next_grid_time >= end_time) begin
      dec_status = ugr_pkg::STATUS_DONE;
    end else if (samples_held == 2'd0) begin
      dec_status = ugr_pkg::STATUS_NEED;
    end else if (next_grid_time > newer_time) begin
      if (final_seen) begin
        dec_value = newer_value;
      end else begin
        dec_status = ugr_pkg::STATUS_NEED;
      end
    end else if (samples_held == 2'd1) begin
      dec_value = newer_value;
    end else if (next_grid_time < older_time) begin
      dec_value = older_value;
    end else if (newer_time == older_time) begin
      dec_value = newer_value;
    end else begin
      dec_interp = 1'b1;
      dec_value  = older_value;
    end
  end

  assign dy     = {newer_value[VW-1], newer_value} - {older_value[VW-1], older_value};
  assign dy_abs = dy[ugr_pkg::DY_W-1] ? (~dy + 1'b1) : dy;

  assign prod    = {p_hi, {ugr_pkg::MUL_SPLIT{1'b0}}}
                 + {{ugr_pkg::MUL_SPLIT{1'b0}}, p_lo};
  assign rem2    = {rem, dvd[VW-1]};
  assign q_bit   = (rem2 >= {1'b0, dx});
  assign rem_sub = rem2 - {1'b0, dx};

  assign nx        = {1'b0, next_grid_time} + (TW + 1)'(grid_step);
  assign fin_value = neg ? (w_value - quo) : (w_value + quo);

  assign stat.tick_interp = dec_interp;
  assign stat.out_free    = !out_valid || m_tready;

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      end_time       <= '0;
      grid_step      <= ugr_pkg::STEP_RESET;
      older_time     <= '0;
      older_value    <= '0;
      newer_time     <= '0;
      newer_value    <= '0;
      samples_held   <= '0;
      final_seen     <= 1'b0;
      next_grid_time <= '0;
      running_min    <= ugr_pkg::VAL_MAX;
      running_max    <= ugr_pkg::VAL_MIN;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ugr_pkg::REG_START_TIME: next_grid_time <= cfg_data[TW-1:0];
          ugr_pkg::REG_END_TIME:   end_time       <= cfg_data[TW-1:0];
          ugr_pkg::REG_GRID_STEP:  grid_step      <= cfg_data[ugr_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.push && !final_seen) begin
        older_time  <= newer_time;
        older_value <= newer_value;
        newer_time  <= st;
        newer_value <= sv;
        if (samples_held != 2'd2) begin
          samples_held <= samples_held + 2'd1;
        end
        if ($signed(sv) < $signed(running_min)) begin
          running_min <= sv;
        end
        if ($signed(sv) > $signed(running_max)) begin
          running_max <= sv;
        end
        if (s_tlast) begin
          final_seen <= 1'b1;
        end
      end
      if (cmd.load_out && (w_status == ugr_pkg::STATUS_VALID)) begin
        next_grid_time <= nx[TW] ? ugr_pkg::TIME_MAX : nx[TW-1:0];
      end
    end
  end

  // interpolation: split multiply then restoring divide
  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      w_time   <= next_grid_time;
      w_status <= dec_status;
      w_value  <= dec_value;
      quo      <= '0;
      neg      <= dec_interp & dy[ugr_pkg::DY_W-1];
      ady      <= dy_abs[VW-1:0];
      dx       <= newer_time - older_time;
      dt       <= next_grid_time - older_time;
    end
    if (cmd.mul_lo) begin
      p_lo <= ugr_pkg::MUL_W'(ady) * ugr_pkg::MUL_W'(dt[ugr_pkg::MUL_SPLIT-1:0]);
    end
    if (cmd.mul_hi) begin
      p_hi <= ugr_pkg::MUL_W'(ady) * ugr_pkg::MUL_W'(dt[TW-1:ugr_pkg::MUL_SPLIT]);
    end
    if (cmd.div_init) begin
      rem <= prod[ugr_pkg::PROD_W-1:VW];
      dvd <= prod[VW-1:0];
    end
    if (cmd.div_step) begin
      rem <= q_bit ? rem_sub[TW-1:0] : rem2[TW-1:0];
      dvd <= {dvd[VW-2:0], 1'b0};
      quo <= {quo[ugr_pkg::QUO_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_time   <= w_time;
      o_value  <= fin_value;
      o_status <= w_status;
      o_min    <= running_min;
      o_max    <= running_max;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{ugr_pkg::OUT_PAD_W{1'b0}}, o_max, o_min, o_value, o_time};
  assign m_tuser  = o_status;

endmodule

// ----- rtl/core/uniform_grid_linear_resampler_top.sv -----
// samples do not make the block busy and may arrive every cycle while no tick is in progress
// a tick outside two samples goes to the output load, which waits for a free output register
// a tick between two samples raises m_tvalid after these steps in order:
// two multiply steps, a divider load, 32 divider steps and the output load
// the result sits in an output register so a new request is taken while it waits
// synchronous active-high reset restores control, configuration and sample state and m_tvalid
module uniform_grid_linear_resampler_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ugr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ugr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ugr_pkg::IN_DATA_W-1:0]     s_tdata,  // sample_time, sample_value
  input  logic                              s_tuser,  // kind
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ugr_pkg::OUT_DATA_W-1:0]    m_tdata,  // grid_time, grid_value, min_value, max_value
  output logic [ugr_pkg::STATUS_W-1:0]      m_tuser   // status
);

  ugr_pkg::ugr_cmd_t   cmd;
  ugr_pkg::ugr_stat_t  stat;

  ugr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_kind   (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ugr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- rtl/core/ugr_checker.sv -----
// port checker of the uniform grid resampler and its bind
`include "uniform_grid_linear_resampler_top_macros.svh"

module ugr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ugr_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic [ugr_pkg::STATUS_W-1:0]      m_tuser
);

  localparam int VAL_LO = ugr_pkg::TIME_W;
  localparam int MIN_LO = ugr_pkg::TIME_W + ugr_pkg::VAL_W;
  localparam int MAX_LO = ugr_pkg::TIME_W + 2 * ugr_pkg::VAL_W;

  logic [ugr_pkg::VAL_W-1:0] grid_value, min_value, max_value;
  logic                      tick_taken;
  logic                      out_held, out_flagged, stats_crossed, stats_empty;

  assign grid_value    = m_tdata[VAL_LO +: ugr_pkg::VAL_W];
  assign min_value     = m_tdata[MIN_LO +: ugr_pkg::VAL_W];
  assign max_value     = m_tdata[MAX_LO +: ugr_pkg::VAL_W];
  assign tick_taken    = s_tvalid && s_tready && (s_tuser == ugr_pkg::KIND_TICK);
  assign out_held      = m_tvalid && !m_tready;
  assign out_flagged   = m_tvalid && (m_tuser != ugr_pkg::STATUS_VALID);
  assign stats_crossed = m_tvalid && ($signed(min_value) > $signed(max_value));
  assign stats_empty   = (min_value == ugr_pkg::VAL_MAX) && (max_value == ugr_pkg::VAL_MIN);

  `UGR_ASSERT_NEXT(a_out_hold, clk, rst, out_held, m_tvalid && $stable(m_tdata))
  `UGR_ASSERT_NOW(a_no_out_after_reset, clk, rst, $past(rst), !m_tvalid)
  `UGR_ASSERT_NEXT(a_tick_busy, clk, rst, tick_taken, !s_tready)
  `UGR_ASSERT_NOW(a_zero_unless_valid, clk, rst, out_flagged, grid_value == '0)
  `UGR_ASSERT_NOW(a_stats_order, clk, rst, stats_crossed, stats_empty)

endmodule

bind uniform_grid_linear_resampler_top ugr_checker u_ugr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
